// ===== design/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	// request codes
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	// result codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_SPACE  = 2'd1,
		STATUS_TOO_LARGE = 2'd2,
		STATUS_BAD_FREE  = 2'd3
	} status_t;

	// tree read address select
	typedef enum logic [2:0] {
		RD_ROOT  = 3'd0,
		RD_LEFT  = 3'd1,
		RD_RIGHT = 3'd2,
		RD_SIB   = 3'd3,
		RD_NODE  = 3'd4
	} rd_sel_t;

	// tree write source select
	typedef enum logic [1:0] {
		WR_CLEAR  = 2'd0,
		WR_MARK   = 2'd1,
		WR_PARENT = 2'd2
	} wr_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    latch_req;
		logic    init;
		logic    latch_left;
		logic    step_down;
		logic    climb;
		logic    mark;
		logic    up_step;
		logic    clr_step;
		logic    load_rsp;
		status_t rsp_code;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
	} bba_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cmd_free;
		logic too_large;
		logic no_space;
		logic at_target;
		logic desc_last;
		logic at_root;
		logic up_last;
		logic misaligned;
		logic node_used;
		logic clr_last;
	} bba_stat_t;

endpackage

`default_nettype wire

// ===== design/bba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	input  bba_pkg::bba_stat_t   stat,
	output bba_pkg::bba_cmd_t    ctl
);
	import bba_pkg::*;

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_DECODE = 13'b0000000000100,
		S_ROOT   = 13'b0000000001000,
		S_DL     = 13'b0000000010000,
		S_DR     = 13'b0000000100000,
		S_DD     = 13'b0000001000000,
		S_MARK   = 13'b0000010000000,
		S_UP_RD  = 13'b0000100000000,
		S_UP_WR  = 13'b0001000000000,
		S_F_RD   = 13'b0010000000000,
		S_F_CHK  = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    rsp_valid_q;
	logic    can_load;

	assign can_load  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d        = state_q;
		code_d         = code_q;
		ctl            = '0;
		ctl.rsp_code   = code_q;
		ctl.rd_sel     = RD_NODE;
		ctl.wr_sel     = WR_CLEAR;
		case (state_q)
			S_CLEAR: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_sel   = WR_CLEAR;
				ctl.clr_step = 1'b1;
				if (stat.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.latch_req = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.init   = 1'b1;
				ctl.rd_sel = RD_ROOT;
				if (stat.cmd_free) begin
					state_d = S_F_RD;
				end else if (stat.too_large) begin
					code_d  = STATUS_TOO_LARGE;
					state_d = S_DONE;
				end else begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				if (stat.no_space) begin
					code_d  = STATUS_NO_SPACE;
					state_d = S_DONE;
				end else if (stat.at_target) begin
					state_d = S_MARK;
				end else begin
					state_d = S_DL;
				end
			end
			S_DL: begin
				ctl.rd_sel = RD_LEFT;
				state_d    = S_DR;
			end
			S_DR: begin
				ctl.rd_sel     = RD_RIGHT;
				ctl.latch_left = 1'b1;
				state_d        = S_DD;
			end
			S_DD: begin
				ctl.step_down = 1'b1;
				state_d       = stat.desc_last ? S_MARK : S_DL;
			end
			S_MARK: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WR_MARK;
				ctl.mark   = 1'b1;
				if (stat.at_root) begin
					code_d  = STATUS_OK;
					state_d = S_DONE;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_UP_RD: begin
				ctl.rd_sel = RD_SIB;
				state_d    = S_UP_WR;
			end
			S_UP_WR: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_sel  = WR_PARENT;
				ctl.up_step = 1'b1;
				if (stat.up_last) begin
					code_d  = STATUS_OK;
					state_d = S_DONE;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_F_RD: begin
				ctl.rd_sel = RD_NODE;
				if (stat.misaligned) begin
					code_d  = STATUS_BAD_FREE;
					state_d = S_DONE;
				end else begin
					state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				if (stat.node_used) begin
					state_d = S_MARK;
				end else if (stat.at_root) begin
					code_d  = STATUS_BAD_FREE;
					state_d = S_DONE;
				end else begin
					ctl.climb = 1'b1;
					state_d   = S_F_RD;
				end
			end
			S_DONE: begin
				if (can_load) begin
					ctl.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, result code and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			code_q      <= STATUS_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (ctl.load_rsp)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== design/bba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath #(
	parameter int TOTAL_SHIFT = 12,
	parameter int MIN_SHIFT   = 6
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cmd,
	input  wire  [TOTAL_SHIFT:0]         request_size,
	input  wire  [TOTAL_SHIFT-1:0]       block_offset,
	output logic [1:0]                   status,
	output logic [TOTAL_SHIFT-1:0]       granted_offset,
	input  bba_pkg::bba_cmd_t            ctl,
	output bba_pkg::bba_stat_t           stat
);
	import bba_pkg::*;

	localparam int LEVELS     = TOTAL_SHIFT - MIN_SHIFT;
	localparam int NODE_W     = LEVELS + 1;
	localparam int NODE_COUNT = (2 ** (LEVELS + 1)) - 1;
	localparam int ORD_W      = $clog2(LEVELS + 2);
	localparam int OFF_W      = TOTAL_SHIFT;
	localparam int SIZE_W     = TOTAL_SHIFT + 1;

	localparam logic [ORD_W-1:0]  ORD_TOP   = ORD_W'(LEVELS + 1);
	localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'((2 ** LEVELS) - 1);
	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
	localparam logic [OFF_W-1:0]  MASK_INIT = OFF_W'((64'd1 << MIN_SHIFT) - 64'd1);
	localparam logic [OFF_W-1:0]  STEP_INIT = OFF_W'(64'd1 << (TOTAL_SHIFT - 1));
	localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(64'd1 << TOTAL_SHIFT);

	// order of the smallest block that holds sz bytes
	function automatic logic [ORD_W-1:0] calc_target(input logic [SIZE_W-1:0] sz);
		logic [ORD_W-1:0] t;
		t = ORD_W'(1);
		for (int i = 0; i < LEVELS; i++) begin
			if (sz > (SIZE_W'(1) << (MIN_SHIFT + i)))
				t = t + ORD_W'(1);
		end
		return t;
	endfunction

	// request and walk registers
	cmd_t              cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic [OFF_W-1:0]  boff_q;
	logic [ORD_W-1:0]  target_q;
	logic [NODE_W-1:0] node_q;
	logic [ORD_W-1:0]  ord_q;
	logic [OFF_W-1:0]  off_acc_q;
	logic [OFF_W-1:0]  step_q;
	logic [OFF_W-1:0]  mask_q;
	logic [ORD_W-1:0]  left_q;
	logic [ORD_W-1:0]  cur_q;
	logic [1:0]        status_q;
	logic [OFF_W-1:0]  granted_q;

	// clearing sweep counters
	logic [NODE_W-1:0] clr_idx_q;
	logic [ORD_W-1:0]  clr_ord_q;
	logic [NODE_W-1:0] clr_end_q;

	// tree memory
	logic [ORD_W-1:0]  tree_q [NODE_COUNT];
	logic [ORD_W-1:0]  rdata_q;
	logic [NODE_W-1:0] rd_addr;
	logic [NODE_W-1:0] wr_addr;
	logic [ORD_W-1:0]  wr_data;

	logic [NODE_W-1:0] left_node;
	logic [NODE_W-1:0] right_node;
	logic [NODE_W-1:0] parent_node;
	logic [NODE_W-1:0] sib_node;
	logic              go_left;
	logic [ORD_W-1:0]  mark_val;
	logic [ORD_W-1:0]  up_l;
	logic [ORD_W-1:0]  up_r;
	logic [ORD_W-1:0]  parent_val;

	// tree neighbours of the current node
	assign left_node   = NODE_W'({node_q, 1'b1});
	assign right_node  = left_node + NODE_W'(1);
	assign parent_node = NODE_W'((node_q - NODE_W'(1)) >> 1);
	assign sib_node    = node_q[0] ? (node_q + NODE_W'(1)) : (node_q - NODE_W'(1));

	// best-fit child choice, left child in rdata-latched left_q, right in rdata_q
	assign go_left = (left_q >= target_q) && ((rdata_q < target_q) || (left_q <= rdata_q));

	// a used block reads zero, a freed one gets its full order back
	assign mark_val = (cmd_q == CMD_FREE) ? ord_q : '0;

	// parent merge: odd node index is a left child
	assign up_l       = node_q[0] ? cur_q : rdata_q;
	assign up_r       = node_q[0] ? rdata_q : cur_q;
	assign parent_val = ((up_l == ord_q) && (up_r == ord_q)) ? (ord_q + ORD_W'(1))
	                  : ((up_l >= up_r) ? up_l : up_r);

	// status towards the controller
	assign stat.cmd_free   = (cmd_q == CMD_FREE);
	assign stat.too_large  = (size_q > SIZE_MAX);
	assign stat.no_space   = (rdata_q < target_q);
	assign stat.at_target  = (ord_q == target_q);
	assign stat.desc_last  = ((ord_q - ORD_W'(1)) == target_q);
	assign stat.at_root    = (ord_q == ORD_TOP);
	assign stat.up_last    = ((ord_q + ORD_W'(1)) == ORD_TOP);
	assign stat.misaligned = ((boff_q & mask_q) != '0);
	assign stat.node_used  = (rdata_q == '0);
	assign stat.clr_last   = (clr_idx_q == LAST_NODE);

	assign status         = status_q;
	assign granted_offset = granted_q;

	// read address select
	always_comb begin
		case (ctl.rd_sel)
			RD_ROOT:  rd_addr = '0;
			RD_LEFT:  rd_addr = left_node;
			RD_RIGHT: rd_addr = right_node;
			RD_SIB:   rd_addr = sib_node;
			RD_NODE:  rd_addr = node_q;
			default:  rd_addr = node_q;
		endcase
	end

	// write address and data select
	always_comb begin
		case (ctl.wr_sel)
			WR_CLEAR: begin
				wr_addr = clr_idx_q;
				wr_data = clr_ord_q;
			end
			WR_MARK: begin
				wr_addr = node_q;
				wr_data = mark_val;
			end
			WR_PARENT: begin
				wr_addr = parent_node;
				wr_data = parent_val;
			end
			default: begin
				wr_addr = node_q;
				wr_data = mark_val;
			end
		endcase
	end

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			tree_q[wr_addr] <= wr_data;
		rdata_q <= tree_q[rd_addr];
	end

	// clearing sweep after reset, level by level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			clr_ord_q <= ORD_TOP;
			clr_end_q <= '0;
		end else if (ctl.clr_step) begin
			clr_idx_q <= clr_idx_q + NODE_W'(1);
			if (clr_idx_q == clr_end_q) begin
				clr_ord_q <= clr_ord_q - ORD_W'(1);
				clr_end_q <= NODE_W'({clr_end_q, 1'b1}) + NODE_W'(1);
			end
		end
	end

	// request capture and tree walk
	always_ff @(posedge clk) begin
		if (ctl.latch_req) begin
			cmd_q  <= cmd_t'(cmd);
			size_q <= request_size;
			boff_q <= block_offset;
		end
		if (ctl.init) begin
			target_q  <= calc_target(size_q);
			off_acc_q <= '0;
			step_q    <= STEP_INIT;
			mask_q    <= MASK_INIT;
			if (cmd_q == CMD_FREE) begin
				node_q <= LEAF_BASE + NODE_W'(boff_q >> MIN_SHIFT);
				ord_q  <= ORD_W'(1);
			end else begin
				node_q <= '0;
				ord_q  <= ORD_TOP;
			end
		end
		if (ctl.latch_left)
			left_q <= rdata_q;
		if (ctl.step_down) begin
			ord_q  <= ord_q - ORD_W'(1);
			step_q <= step_q >> 1;
			if (go_left) begin
				node_q <= left_node;
			end else begin
				node_q    <= right_node;
				off_acc_q <= off_acc_q | step_q;
			end
		end
		if (ctl.climb) begin
			node_q <= parent_node;
			ord_q  <= ord_q + ORD_W'(1);
			mask_q <= OFF_W'({mask_q, 1'b1});
		end
		if (ctl.mark)
			cur_q <= mark_val;
		if (ctl.up_step) begin
			node_q <= parent_node;
			ord_q  <= ord_q + ORD_W'(1);
			cur_q  <= parent_val;
		end
		if (ctl.load_rsp) begin
			status_q <= ctl.rsp_code;
			if ((ctl.rsp_code == STATUS_OK) && (cmd_q == CMD_ALLOC))
				granted_q <= off_acc_q;
			else
				granted_q <= '0;
		end
	end

endmodule

`default_nettype wire

// ===== design/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary buddy allocator over a 2^TOTAL_SHIFT byte region in blocks of at least
// 2^MIN_SHIFT bytes. Each request (cmd 0 allocate request_size bytes, cmd 1 free
// the block at block_offset) gives one result beat with status and granted_offset.
// The free-order tree lives in a single-port-write, single-port-read memory with
// registered read data, and the walk is paced by that memory: an allocate reads both
// children at each level descended and rewrites each parent on the way back up; a free
// searches upward from the leaf to the first used node and then merges upward, with
// L = TOTAL_SHIFT - MIN_SHIFT levels. A request that is rejected at its first check
// finishes without walking the tree. After reset a clearing sweep writes every tree
// node once, 2^(L+1) - 1 nodes (127 at L = 6), before the first request is taken.
// A new request is taken while the last result beat is still stalled at the output.
module buddy_block_allocator #(
	parameter int TOTAL_SHIFT = 12,
	parameter int MIN_SHIFT   = 6
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_stall,
	input  wire                    cmd,
	input  wire  [TOTAL_SHIFT:0]   request_size,
	input  wire  [TOTAL_SHIFT-1:0] block_offset,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output logic [1:0]             status,
	output logic [TOTAL_SHIFT-1:0] granted_offset
);
	import bba_pkg::*;

	bba_cmd_t  ctl;
	bba_stat_t stat;

	// sequencer
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// tree memory and walk registers
	bba_datapath #(
		.TOTAL_SHIFT (TOTAL_SHIFT),
		.MIN_SHIFT   (MIN_SHIFT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.request_size   (request_size),
		.block_offset   (block_offset),
		.status         (status),
		.granted_offset (granted_offset),
		.ctl            (ctl),
		.stat           (stat)
	);

endmodule

`default_nettype wire

// ===== bench/buddy_alloc_checker.sv =====
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the free-order tree and
// compares every result beat against the oldest predicted reply
module buddy_alloc_checker #(
	parameter int TOTAL_SHIFT = 12,
	parameter int MIN_SHIFT   = 6
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	input  wire                   req_stall,
	input  wire                   cmd,
	input  wire [TOTAL_SHIFT:0]   request_size,
	input  wire [TOTAL_SHIFT-1:0] block_offset,
	input  wire                   rsp_valid,
	input  wire                   rsp_stall,
	input  wire [1:0]             status,
	input  wire [TOTAL_SHIFT-1:0] granted_offset,
	output int                    fail_count,
	output int                    backlog
);
	import bba_pkg::*;

	localparam int LEVELS = TOTAL_SHIFT - MIN_SHIFT;
	localparam int NODES  = (2 << LEVELS) - 1;

	typedef struct packed {
		status_t                status;
		logic [TOTAL_SHIFT-1:0] offset;
	} reply_t;

	reply_t     pending_replies[$];
	logic [2:0] order_tree [NODES];
	reply_t     want_reply;

	// order of a whole free node at a given depth, leaves are 1
	function automatic logic [2:0] level_order(input int depth);
		return 3'(LEVELS - depth + 1);
	endfunction

	// whole region free
	function automatic void restore_tree();
		int idx;
		idx = 0;
		for (int depth = 0; depth <= LEVELS; depth++) begin
			for (int k = 0; k < (1 << depth); k++) begin
				order_tree[idx] = level_order(depth);
				idx++;
			end
		end
	endfunction

	// recompute ancestors, two whole buddies merge into a whole parent
	function automatic void merge_upward(input int start, input int start_depth);
		int         node;
		int         depth;
		logic [2:0] lo;
		logic [2:0] ro;
		logic [2:0] child_full;
		node  = start;
		depth = start_depth;
		while (node > 0 && depth > 0) begin
			node       = (node - 1) / 2;
			depth      = depth - 1;
			child_full = level_order(depth + 1);
			lo         = order_tree[2 * node + 1];
			ro         = order_tree[2 * node + 2];
			if (lo == child_full && ro == child_full)
				order_tree[node] = level_order(depth);
			else
				order_tree[node] = (lo >= ro) ? lo : ro;
		end
	endfunction

	// best-fit descent, left child on a tie
	function automatic reply_t grant_block(input logic [TOTAL_SHIFT:0] size);
		reply_t     r;
		int         k;
		int         node;
		int         depth;
		int         off;
		logic [2:0] want;
		logic [2:0] lo;
		logic [2:0] ro;
		r.status = STATUS_OK;
		r.offset = '0;
		if (size > (1 << TOTAL_SHIFT)) begin
			r.status = STATUS_TOO_LARGE;
			return r;
		end
		k = MIN_SHIFT;
		while (k < TOTAL_SHIFT && (1 << k) < size)
			k++;
		want = 3'(k - MIN_SHIFT + 1);
		if (order_tree[0] < want) begin
			r.status = STATUS_NO_SPACE;
			return r;
		end
		node  = 0;
		depth = 0;
		off   = 0;
		while (level_order(depth) > want) begin
			lo = order_tree[2 * node + 1];
			ro = order_tree[2 * node + 2];
			if (lo >= want && (ro < want || lo <= ro)) begin
				node = 2 * node + 1;
			end else begin
				node = 2 * node + 2;
				off  = off + (1 << (TOTAL_SHIFT - depth - 1));
			end
			depth++;
		end
		order_tree[node] = '0;
		merge_upward(node, depth);
		r.offset = TOTAL_SHIFT'(off);
		return r;
	endfunction

	// climb from the leaf to the first used node, which must start at off
	function automatic reply_t release_block(input logic [TOTAL_SHIFT-1:0] off);
		reply_t r;
		int     node;
		int     depth;
		r.status = STATUS_BAD_FREE;
		r.offset = '0;
		node     = (NODES >> 1) + int'(off >> MIN_SHIFT);
		depth    = LEVELS;
		while (1) begin
			if ((int'(off) & ((1 << (TOTAL_SHIFT - depth)) - 1)) != 0)
				return r;
			if (order_tree[node] == '0)
				break;
			if (depth == 0)
				return r;
			node  = (node - 1) / 2;
			depth = depth - 1;
		end
		order_tree[node] = level_order(depth);
		merge_upward(node, depth);
		r.status = STATUS_OK;
		return r;
	endfunction

	// result beats are matched before new requests are predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_tree();
			pending_replies.delete();
			fail_count = 0;
			backlog <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_replies.size() == 0) begin
					$error("result beat with no request waiting: status %0d offset %0d",
						status, granted_offset);
					fail_count++;
				end else begin
					want_reply = pending_replies.pop_front();
					if (status !== want_reply.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want_reply.status, status);
						fail_count++;
					end
					if (granted_offset !== want_reply.offset) begin
						$error("granted_offset mismatch: expected %0d, actual %0d",
							want_reply.offset, granted_offset);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (cmd == CMD_FREE)
					pending_replies.push_back(release_block(block_offset));
				else
					pending_replies.push_back(grant_block(request_size));
			end
			backlog <= pending_replies.size();
		end
	end

endmodule

// ===== bench/buddy_block_allocator_tb.sv =====
`timescale 1ns / 1ps

module buddy_block_allocator_tb;
	import bba_pkg::*;

	localparam int TOTAL_SHIFT  = 12;
	localparam int MIN_SHIFT    = 6;
	localparam int RANDOM_ITEMS = 1500;
	localparam int QUIET_ITEMS  = 150;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   req_valid  = 1'b0;
	cmd_t                   req_cmd    = CMD_ALLOC;
	logic [TOTAL_SHIFT:0]   req_size   = '0;
	logic [TOTAL_SHIFT-1:0] req_offset = '0;
	logic                   rsp_stall  = 1'b0;
	logic                   quiet      = 1'b0;
	int                     stall_run  = 0;

	wire                    req_stall;
	wire                    rsp_valid;
	wire [1:0]              status;
	wire [TOTAL_SHIFT-1:0]  granted_offset;
	int                     fail_count;
	int                     backlog;

	// requests in flight and blocks believed granted, for picking frees
	cmd_t                   sent_cmds[$];
	logic [TOTAL_SHIFT-1:0] live_blocks[$];
	cmd_t                   done_cmd;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	buddy_block_allocator #(
		.TOTAL_SHIFT(TOTAL_SHIFT),
		.MIN_SHIFT  (MIN_SHIFT)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.cmd           (req_cmd),
		.request_size  (req_size),
		.block_offset  (req_offset),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.granted_offset(granted_offset)
	);

	buddy_alloc_checker #(
		.TOTAL_SHIFT(TOTAL_SHIFT),
		.MIN_SHIFT  (MIN_SHIFT)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.cmd           (req_cmd),
		.request_size  (req_size),
		.block_offset  (req_offset),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.granted_offset(granted_offset),
		.fail_count    (fail_count),
		.backlog       (backlog)
	);

	// result side stalls in bursts, runs of open cycles between
	always @(posedge clk) begin
		if (quiet) begin
			rsp_stall <= 1'b0;
		end else if (stall_run == 0) begin
			stall_run <= $urandom_range(0, 15);
			rsp_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			stall_run <= stall_run - 1;
		end
	end

	// note granted blocks at the falling edge ahead of the accepting edge
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && sent_cmds.size() != 0) begin
			done_cmd = sent_cmds.pop_front();
			if (done_cmd == CMD_ALLOC && status == STATUS_OK)
				live_blocks.push_back(granted_offset);
		end
	end

	// one request beat, held until taken, with an occasional gap ahead of it
	task automatic send_item(input cmd_t c, input logic [TOTAL_SHIFT:0] size,
			input logic [TOTAL_SHIFT-1:0] off);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		req_cmd    <= c;
		req_size   <= size;
		req_offset <= off;
		do @(posedge clk); while (req_stall);
		sent_cmds.push_back(c);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic alloc_item(input int size);
		send_item(CMD_ALLOC, (TOTAL_SHIFT + 1)'(size), TOTAL_SHIFT'($urandom));
	endtask

	task automatic free_item(input int off);
		send_item(CMD_FREE, (TOTAL_SHIFT + 1)'($urandom), TOTAL_SHIFT'(off));
	endtask

	// mostly sizes that fit, a few too large; frees mostly of granted blocks
	task automatic send_random();
		int                     r;
		int                     idx;
		int                     size;
		logic [TOTAL_SHIFT-1:0] off;
		r = $urandom_range(0, 99);
		if (live_blocks.size() == 0 || r < (live_blocks.size() > 24 ? 35 : 55)) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				size = 0;
			else if (r < 50)
				size = $urandom_range(1, 128);
			else if (r < 75)
				size = $urandom_range(129, 512);
			else if (r < 88)
				size = $urandom_range(513, 2048);
			else if (r < 93)
				size = $urandom_range(2049, 4096);
			else if (r < 96)
				size = 1 << $urandom_range(0, 12);
			else
				size = $urandom_range(4097, 8191);
			alloc_item(size);
		end else begin
			r   = $urandom_range(0, 99);
			idx = $urandom_range(0, live_blocks.size() - 1);
			if (r < 72) begin
				off = live_blocks[idx];
				live_blocks.delete(idx);
			end else if (r < 82) begin
				off = live_blocks[idx] + TOTAL_SHIFT'(64 * $urandom_range(1, 3));
			end else if (r < 88) begin
				off = live_blocks[idx] + TOTAL_SHIFT'($urandom_range(1, 63));
			end else if (r < 95) begin
				off = TOTAL_SHIFT'($urandom_range(0, 63) << MIN_SHIFT);
			end else begin
				off = TOTAL_SHIFT'($urandom);
			end
			free_item(off);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// small blocks, rounding up, best fit
		alloc_item(0);
		alloc_item(1);
		alloc_item(64);
		alloc_item(65);
		// misaligned, inside a used block, never used, last byte
		free_item(32);
		free_item(320);
		free_item(4032);
		free_item(4095);
		free_item(64);
		free_item(128);
		free_item(256);
		// whole region blocked by one small block
		alloc_item(4096);
		free_item(0);
		free_item(0);
		// whole region, then nothing left
		alloc_item(4096);
		alloc_item(1);
		alloc_item(4097);
		alloc_item(8191);
		free_item(0);
		// two halves fill the region
		alloc_item(2048);
		alloc_item(2048);
		alloc_item(0);
		free_item(2048);
		free_item(0);
		wait_drained();
		live_blocks.delete();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet <= 1'b1;
			send_random();
		end

		wait_drained();
		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bba_pkg.sv
design/bba_ctrl.sv
design/bba_datapath.sv
design/buddy_block_allocator.sv
bench/buddy_alloc_checker.sv
bench/buddy_block_allocator_tb.sv
